### rtl/tpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle perimeter and area: shared constants
// Field widths and the widths of the internal arithmetic.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int COORD_BITS     = 12;
    localparam int FRAC_BITS      = 8;
    // Magnitude of a coordinate difference and the sum of two squares.
    localparam int DIFF_BITS      = COORD_BITS;
    localparam int SQ_BITS        = 2 * DIFF_BITS + 1;
    // Side radicand is the squared length scaled by 2^(2*FRAC_BITS), made even.
    localparam int SIDE_RAD_BITS  = ((SQ_BITS + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int SIDE_BITS      = SIDE_RAD_BITS / 2;
    localparam int PERIM_BITS     = 23;
    localparam int AREA_BITS      = 31;
    localparam int HALF_BITS      = PERIM_BITS;
    localparam int PAIR_BITS      = 2 * PERIM_BITS;
    localparam int PROD_BITS      = 4 * PERIM_BITS;
    localparam int AREA_ROOT_BITS = PROD_BITS / 2;
    localparam int AREA_SHIFT     = FRAC_BITS + 2;
    localparam int IN_DATA_BITS   = 72;
    localparam int OUT_DATA_BITS  = 56;

endpackage

### rtl/tpa_side_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Side length pipeline
// Absolute differences, sum of squares, then one root bit per stage.
// ----------------------------------------------------------------------------
module tpa_side_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [tpa_pkg::COORD_BITS-1:0] x0,
    input  logic signed [tpa_pkg::COORD_BITS-1:0] y0,
    input  logic signed [tpa_pkg::COORD_BITS-1:0] x1,
    input  logic signed [tpa_pkg::COORD_BITS-1:0] y1,
    output logic                                  out_valid,
    output logic        [tpa_pkg::SIDE_BITS-1:0]  len
);

    localparam int K  = tpa_pkg::SIDE_BITS;
    localparam int RW = tpa_pkg::SIDE_RAD_BITS;
    localparam int DW = tpa_pkg::DIFF_BITS;

    logic signed [DW:0]               dx;
    logic signed [DW:0]               dy;
    logic        [DW:0]               adx;
    logic        [DW:0]               ady;
    logic        [DW-1:0]             adx_reg;
    logic        [DW-1:0]             ady_reg;
    logic        [2*DW-1:0]           sqx;
    logic        [2*DW-1:0]           sqy;
    logic                             va_reg;
    logic        [tpa_pkg::SQ_BITS-1:0] sq_reg;
    logic                             vb_reg;

    logic [K+1:0] rem_reg  [1:K];
    logic [K-1:0] root_reg [1:K];
    logic [RW-1:0] rad_reg [1:K];
    logic         v_reg    [1:K];

    assign dx  = $signed({x0[DW-1], x0}) - $signed({x1[DW-1], x1});
    assign dy  = $signed({y0[DW-1], y0}) - $signed({y1[DW-1], y1});
    assign adx = dx[DW] ? (DW+1)'(-dx) : dx;
    assign ady = dy[DW] ? (DW+1)'(-dy) : dy;
    assign sqx = adx_reg * adx_reg;
    assign sqy = ady_reg * ady_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adx_reg <= adx[DW-1:0];
            ady_reg <= ady[DW-1:0];
            sq_reg  <= tpa_pkg::SQ_BITS'(sqx) + tpa_pkg::SQ_BITS'(sqy);
        end
    end

    genvar i;
    generate
        for (i = 0; i < K; i++)
        begin : g_root
            logic [K+1:0]  rem_cur;
            logic [K-1:0]  root_cur;
            logic [RW-1:0] rad_cur;
            logic          v_cur;
            logic [K+1:0]  rs;
            logic [K+1:0]  tr;
            logic          ge;

            if (i == 0)
            begin : g_first
                assign rem_cur  = '0;
                assign root_cur = '0;
                assign rad_cur  = RW'({sq_reg, {(2 * tpa_pkg::FRAC_BITS){1'b0}}});
                assign v_cur    = vb_reg;
            end
            else
            begin : g_next
                assign rem_cur  = rem_reg[i];
                assign root_cur = root_reg[i];
                assign rad_cur  = rad_reg[i];
                assign v_cur    = v_reg[i];
            end

            assign rs = {rem_cur[K-1:0], rad_cur[RW-1:RW-2]};
            assign tr = {root_cur, 2'b01};
            assign ge = (rs >= tr);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i+1] <= 1'b0;
                else if (en)
                    v_reg[i+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1]  <= ge ? rs - tr : rs;
                    root_reg[i+1] <= {root_cur[K-2:0], ge};
                    rad_reg[i+1]  <= {rad_cur[RW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[K];
    assign len       = root_reg[K];

endmodule

### rtl/tpa_area_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perimeter and Heron area pipeline
// Perimeter, clamped factors, split product, then one root bit per stage.
// ----------------------------------------------------------------------------
module tpa_area_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [tpa_pkg::SIDE_BITS-1:0]      sab,
    input  logic [tpa_pkg::SIDE_BITS-1:0]      sac,
    input  logic [tpa_pkg::SIDE_BITS-1:0]      scb,
    output logic                               out_valid,
    output logic [tpa_pkg::PERIM_BITS-1:0]     perimeter,
    output logic [tpa_pkg::AREA_BITS-1:0]      area
);

    localparam int PB = tpa_pkg::PERIM_BITS;
    localparam int HB = tpa_pkg::HALF_BITS;
    localparam int WB = tpa_pkg::PAIR_BITS;
    localparam int RW = tpa_pkg::PROD_BITS;
    localparam int K  = tpa_pkg::AREA_ROOT_BITS;
    localparam int SB = tpa_pkg::SIDE_BITS;

    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic [PB-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [SB-1:0] a1_reg, b1_reg, c1_reg;
    logic [PB-1:0] f1_reg, f2_reg, f3_reg;
    logic [WB-1:0] left_reg, right_reg;
    logic [WB-1:0] ll_reg, hh_reg;
    logic [WB-1:0] lh, hl;
    logic [WB:0]   mid_reg;
    logic [RW-1:0] prod_reg;
    logic [PB-1:0] perim_out_reg;
    logic [tpa_pkg::AREA_BITS-1:0] area_out_reg;

    logic signed [PB+1:0] fa, fb, fc;
    logic [K-tpa_pkg::AREA_SHIFT-1:0] area_wide;

    logic [K+1:0]  rem_reg   [1:K];
    logic [K-1:0]  root_reg  [1:K];
    logic [RW-1:0] rad_reg   [1:K];
    logic [PB-1:0] perim_reg [1:K];
    logic          v_reg     [1:K];

    // A factor below zero comes only from truncated side lengths.
    assign fa = $signed({2'b00, p1_reg}) - $signed((PB+2)'({a1_reg, 1'b0}));
    assign fb = $signed({2'b00, p1_reg}) - $signed((PB+2)'({b1_reg, 1'b0}));
    assign fc = $signed({2'b00, p1_reg}) - $signed((PB+2)'({c1_reg, 1'b0}));

    assign lh = left_reg[HB-1:0] * right_reg[WB-1:HB];
    assign hl = left_reg[WB-1:HB] * right_reg[HB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vo_reg <= v_reg[K];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= PB'(sab) + PB'(sac) + PB'(scb);
            a1_reg    <= sab;
            b1_reg    <= sac;
            c1_reg    <= scb;
            p2_reg    <= p1_reg;
            f1_reg    <= fa[PB+1] ? '0 : fa[PB-1:0];
            f2_reg    <= fb[PB+1] ? '0 : fb[PB-1:0];
            f3_reg    <= fc[PB+1] ? '0 : fc[PB-1:0];
            p3_reg    <= p2_reg;
            left_reg  <= p2_reg * f1_reg;
            right_reg <= f2_reg * f3_reg;
            p4_reg    <= p3_reg;
            ll_reg    <= left_reg[HB-1:0] * right_reg[HB-1:0];
            hh_reg    <= left_reg[WB-1:HB] * right_reg[WB-1:HB];
            mid_reg   <= (WB+1)'(lh) + (WB+1)'(hl);
            p5_reg    <= p4_reg;
            prod_reg  <= RW'(ll_reg) + (RW'(mid_reg) << HB) + (RW'(hh_reg) << WB);
        end
    end

    genvar i;
    generate
        for (i = 0; i < K; i++)
        begin : g_root
            logic [K+1:0]  rem_cur;
            logic [K-1:0]  root_cur;
            logic [RW-1:0] rad_cur;
            logic [PB-1:0] perim_cur;
            logic          v_cur;
            logic [K+1:0]  rs;
            logic [K+1:0]  tr;
            logic          ge;

            if (i == 0)
            begin : g_first
                assign rem_cur   = '0;
                assign root_cur  = '0;
                assign rad_cur   = prod_reg;
                assign perim_cur = p5_reg;
                assign v_cur     = v5_reg;
            end
            else
            begin : g_next
                assign rem_cur   = rem_reg[i];
                assign root_cur  = root_reg[i];
                assign rad_cur   = rad_reg[i];
                assign perim_cur = perim_reg[i];
                assign v_cur     = v_reg[i];
            end

            assign rs = {rem_cur[K-1:0], rad_cur[RW-1:RW-2]};
            assign tr = {root_cur, 2'b01};
            assign ge = (rs >= tr);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i+1] <= 1'b0;
                else if (en)
                    v_reg[i+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1]   <= ge ? rs - tr : rs;
                    root_reg[i+1]  <= {root_cur[K-2:0], ge};
                    rad_reg[i+1]   <= {rad_cur[RW-3:0], 2'b00};
                    perim_reg[i+1] <= perim_cur;
                end
            end
        end
    endgenerate

    assign area_wide = root_reg[K][K-1:tpa_pkg::AREA_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            perim_out_reg <= perim_reg[K];
            area_out_reg  <= (|area_wide[K-tpa_pkg::AREA_SHIFT-1:tpa_pkg::AREA_BITS])
                           ? '1 : area_wide[tpa_pkg::AREA_BITS-1:0];
        end
    end

    assign out_valid = vo_reg;
    assign perimeter = perim_out_reg;
    assign area      = area_out_reg;

endmodule

### rtl/triangle_perimeter_area_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle perimeter and area
// Streams triangles in and returns perimeter and Heron area in Q.8.
// ----------------------------------------------------------------------------
// One triangle is taken every cycle unless an output word is stalled, and each
// word yields exactly one result. The pipeline runs difference and squaring,
// the side root (one bit per stage), perimeter, factors and the split 92-bit
// product, the area root and one output register.
// The whole pipeline advances together; it holds while an output word waits.
module triangle_perimeter_area_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // ax[11:0], ay[23:12], bx[35:24], by_coord[47:36], cx[59:48], cy[71:60]
    input  logic [tpa_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // perimeter[22:0], area[53:23], zero pad[55:54]
    output logic [tpa_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam int CB = tpa_pkg::COORD_BITS;

    logic                             en;
    logic                             v_ab, v_ac, v_cb;
    logic [tpa_pkg::SIDE_BITS-1:0]    sab, sac, scb;
    logic [tpa_pkg::PERIM_BITS-1:0]   perimeter;
    logic [tpa_pkg::AREA_BITS-1:0]    area;
    logic signed [CB-1:0]             ax, ay, bx, by_coord, cx, cy;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign ax       = s_tdata[CB-1:0];
    assign ay       = s_tdata[2*CB-1:CB];
    assign bx       = s_tdata[3*CB-1:2*CB];
    assign by_coord = s_tdata[4*CB-1:3*CB];
    assign cx       = s_tdata[5*CB-1:4*CB];
    assign cy       = s_tdata[6*CB-1:5*CB];

    tpa_side_unit u_side_ab
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .x0(ax), .y0(ay), .x1(bx), .y1(by_coord),
        .out_valid(v_ab), .len(sab)
    );

    tpa_side_unit u_side_ac
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .x0(ax), .y0(ay), .x1(cx), .y1(cy),
        .out_valid(v_ac), .len(sac)
    );

    tpa_side_unit u_side_cb
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .x0(cx), .y0(cy), .x1(bx), .y1(by_coord),
        .out_valid(v_cb), .len(scb)
    );

    tpa_area_unit u_area
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_ab && v_ac && v_cb),
        .sab(sab), .sac(sac), .scb(scb),
        .out_valid(m_tvalid), .perimeter(perimeter), .area(area)
    );

    assign m_tdata = {2'b00, area, perimeter};

endmodule

### rtl/tpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the stream ports of the triangle block.
// ----------------------------------------------------------------------------
module tpa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // An empty output stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no output word pending");

    // A stalled output word stalls the whole pipeline.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output is stalled");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output word changed while stalled");

endmodule

bind triangle_perimeter_area_top tpa_checker u_tpa_checker
(
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
